### hw/rtl/sopl_pkg.sv
// Shared constants, entry type and cell control codes for the ordered packet list.
package sopl_pkg;

  localparam int DEPTH       = 128;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int POS_W       = 7;
  localparam int HND_IO_W    = 16;
  localparam int SEQ_W       = 32;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int HW_W        = (HANDLE_BITS > HND_IO_W) ? HANDLE_BITS : HND_IO_W;
  localparam int C8_W        = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [2:0] OP_APPEND   = 3'd0;
  localparam logic [2:0] OP_POP      = 3'd1;
  localparam logic [2:0] OP_REMOVE   = 3'd2;
  localparam logic [2:0] OP_SORT     = 3'd3;
  localparam logic [2:0] OP_CONTAINS = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [SEQ_W-1:0]       seq;
    logic [HANDLE_BITS-1:0] handle;
    logic [IDX_W-1:0]       tag;
  } entry_t;

  typedef enum logic [2:0] {
    SEL_KEEP,
    SEL_LOAD,
    SEL_NEXT,
    SEL_PREV,
    SEL_HEAD,
    SEL_TAG
  } sel_t;

endpackage

### hw/rtl/sopl_cell.sv
// One list slot: holds an entry and loads from its neighbors, the head or the append data, or takes its index as tag.
module sopl_cell (
  input  logic             clk,
  input  sopl_pkg::sel_t   sel,
  input  sopl_pkg::entry_t load,
  input  sopl_pkg::entry_t next,
  input  sopl_pkg::entry_t prev,
  input  sopl_pkg::entry_t head,
  input  logic [sopl_pkg::IDX_W-1:0] tag_val,
  output sopl_pkg::entry_t ent,
  output logic             gt
);

  // Tag breaks ties: a later original position sorts first.
  assign gt = {ent.seq, ~ent.tag} > {next.seq, ~next.tag};

  always_ff @(posedge clk) begin
    case (sel)
      sopl_pkg::SEL_LOAD: ent <= load;
      sopl_pkg::SEL_NEXT: ent <= next;
      sopl_pkg::SEL_PREV: ent <= prev;
      sopl_pkg::SEL_HEAD: ent <= head;
      sopl_pkg::SEL_TAG:  ent.tag <= tag_val;
      default: ent <= ent;
    endcase
  end

endmodule

### hw/rtl/seq_ordered_packet_list.sv
// Ordered packet list: append, pop, remove at position, sort and contains over a row of cells.
// Append, pop and remove present their result in the cycle after the input transfer.
// Contains rotates the list once through the head cell.
// Sort is an odd-even transposition over the cell row.
// One operation at a time; the next input is taken once the result register is free.
// rst (synchronous) empties the list and drops any pending result; entries are not cleared.
module seq_ordered_packet_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // seq_number[31:0], packet_handle[47:32], position[54:48]
  input  logic [2:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_seq[31:0], out_handle[47:32], found[48],
                                 // entry_count[56:49], is_empty_flag[57]
  output logic [1:0]  m_tuser    // status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  localparam int D = sopl_pkg::DEPTH;

  logic [1:0]                    state;
  logic [sopl_pkg::CNT_W-1:0]    count;
  logic [sopl_pkg::CNT_W-1:0]    count_next;
  logic [sopl_pkg::CNT_W-1:0]    phase;
  logic [sopl_pkg::SEQ_W-1:0]    key;
  logic                          found;

  logic [sopl_pkg::SEQ_W-1:0]    o_seq;
  logic [sopl_pkg::HND_IO_W-1:0] o_handle;
  logic                          o_found;
  logic [1:0]                    o_status;
  logic [7:0]                    o_count;
  logic                          o_empty;

  sopl_pkg::entry_t              ent [D];
  sopl_pkg::sel_t                sel [D];
  logic [D-1:0]                  gt;
  sopl_pkg::entry_t              load;

  logic                          accept;
  logic                          out_free;
  logic                          out_load;
  logic                          running;
  logic                          finish;
  logic [2:0]                    op;
  logic [sopl_pkg::CMP_W-1:0]    count_c;
  logic [sopl_pkg::CMP_W-1:0]    pos_c;
  logic                          is_full;
  logic                          is_zero;
  logic                          remove_ok;
  logic [sopl_pkg::HW_W-1:0]     hnd_in_w;
  logic [sopl_pkg::HW_W-1:0]     hnd_out_w;
  logic [sopl_pkg::C8_W-1:0]     cnt8_w;
  logic [sopl_pkg::C8_W-1:0]     cnt8_cur_w;
  logic [1:0]                    status_now;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign op       = s_tuser;

  assign count_c   = sopl_pkg::CMP_W'(count);
  assign pos_c     = sopl_pkg::CMP_W'(s_tdata[54:48]);
  assign is_full   = (count == sopl_pkg::CNT_W'(D));
  assign is_zero   = (count == '0);
  assign remove_ok = !is_zero && (pos_c < count_c);
  assign running   = (state != S_IDLE) && (phase != count);
  assign finish    = (state != S_IDLE) && (phase == count) && out_free;
  assign out_load  = (accept && (op != sopl_pkg::OP_SORT) && (op != sopl_pkg::OP_CONTAINS))
                     || finish;

  assign hnd_in_w    = sopl_pkg::HW_W'(s_tdata[47:32]);
  assign load.seq    = s_tdata[31:0];
  assign load.handle = hnd_in_w[sopl_pkg::HANDLE_BITS-1:0];
  assign load.tag    = '0;
  assign hnd_out_w   = sopl_pkg::HW_W'(ent[0].handle);

  always_comb begin
    count_next = count;
    status_now = sopl_pkg::ST_OK;
    case (op)
      sopl_pkg::OP_APPEND: begin
        if (is_full) status_now = sopl_pkg::ST_FULL;
        else count_next = count + 1'b1;
      end
      sopl_pkg::OP_POP: begin
        if (is_zero) status_now = sopl_pkg::ST_EMPTY;
        else count_next = count - 1'b1;
      end
      sopl_pkg::OP_REMOVE: begin
        if (is_zero) status_now = sopl_pkg::ST_EMPTY;
        else if (!remove_ok) status_now = sopl_pkg::ST_RANGE;
        else count_next = count - 1'b1;
      end
      default: ;
    endcase
  end

  assign cnt8_w     = sopl_pkg::C8_W'(count_next);
  assign cnt8_cur_w = sopl_pkg::C8_W'(count);

  genvar i;
  generate
    for (i = 0; i < D; i++) begin : g_cell
      localparam logic [sopl_pkg::CMP_W-1:0] I_C  = sopl_pkg::CMP_W'(i);
      localparam logic [sopl_pkg::CMP_W-1:0] I1_C = sopl_pkg::CMP_W'(i + 1);
      localparam logic                       ODD  = (i % 2) == 1;

      sopl_pkg::entry_t nxt;
      sopl_pkg::entry_t prv;
      logic             gt_prev;

      if (i < D - 1) begin : g_nx
        assign nxt = ent[i+1];
      end else begin : g_nx_end
        assign nxt = ent[i];
      end

      if (i > 0) begin : g_pv
        assign prv     = ent[i-1];
        assign gt_prev = gt[i-1];
      end else begin : g_pv_end
        assign prv     = ent[i];
        assign gt_prev = 1'b0;
      end

      always_comb begin
        sel[i] = sopl_pkg::SEL_KEEP;
        if (accept) begin
          case (op)
            sopl_pkg::OP_APPEND:
              if (!is_full && (I_C == count_c)) sel[i] = sopl_pkg::SEL_LOAD;
            sopl_pkg::OP_POP:
              if (!is_zero) sel[i] = sopl_pkg::SEL_NEXT;
            sopl_pkg::OP_REMOVE:
              if (remove_ok && (I_C >= pos_c)) sel[i] = sopl_pkg::SEL_NEXT;
            sopl_pkg::OP_SORT:
              sel[i] = sopl_pkg::SEL_TAG;
            default: ;
          endcase
        end else if (running && (state == S_SORT)) begin
          // Pair this cell with the one above on matching parity, else with the one below.
          if ((ODD == phase[0]) && (I1_C < count_c) && gt[i])
            sel[i] = sopl_pkg::SEL_NEXT;
          else if ((ODD != phase[0]) && (I_C < count_c) && gt_prev)
            sel[i] = sopl_pkg::SEL_PREV;
        end else if (running && (state == S_FIND)) begin
          // Rotate the occupied part one place toward the head.
          if (I1_C < count_c) sel[i] = sopl_pkg::SEL_NEXT;
          else if (I1_C == count_c) sel[i] = sopl_pkg::SEL_HEAD;
        end
      end

      sopl_cell u_cell (
        .clk     (clk),
        .sel     (sel[i]),
        .load    (load),
        .next    (nxt),
        .prev    (prv),
        .head    (ent[0]),
        .tag_val (sopl_pkg::IDX_W'(i)),
        .ent     (ent[i]),
        .gt      (gt[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      phase    <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) m_tvalid <= 1'b0;

      if (accept) begin
        count <= count_next;
        phase <= '0;
        found <= 1'b0;
        key   <= s_tdata[31:0];
        if (op == sopl_pkg::OP_SORT) begin
          state <= S_SORT;
        end else if (op == sopl_pkg::OP_CONTAINS) begin
          state <= S_FIND;
        end else begin
          m_tvalid <= 1'b1;
          o_seq    <= (op == sopl_pkg::OP_POP && !is_zero) ? ent[0].seq : '0;
          o_handle <= (op == sopl_pkg::OP_POP && !is_zero) ? hnd_out_w[15:0] : '0;
          o_found  <= 1'b0;
          o_status <= status_now;
          o_count  <= cnt8_w[7:0];
          o_empty  <= (count_next == '0);
        end
      end else if (running) begin
        phase <= phase + 1'b1;
        if ((state == S_FIND) && (ent[0].seq == key)) found <= 1'b1;
      end else if (finish) begin
        state    <= S_IDLE;
        m_tvalid <= 1'b1;
        o_seq    <= '0;
        o_handle <= '0;
        o_found  <= (state == S_FIND) && found;
        o_status <= sopl_pkg::ST_OK;
        o_count  <= cnt8_cur_w[7:0];
        o_empty  <= is_zero;
      end
    end
  end

  assign m_tdata = {6'd0, o_empty, o_count, o_found, o_handle, o_seq};
  assign m_tuser = o_status;

endmodule
